### hdl/pidv_pkg.sv
// shared types, register indexes and reset values for the pid voltage controller
`timescale 1ns / 1ps

package pidv_pkg;

	localparam int SAMPLE_W = 8;
	localparam int ERR_W    = SAMPLE_W + 1;
	localparam int GAIN_W   = 16;
	localparam int LIMIT_W  = 16;
	localparam int SUM_W    = 18;
	localparam int IDX_W    = 3;
	localparam int DATA_W   = 16;

	typedef enum logic [1:0] {
		SAT_NONE = 2'd0,
		SAT_HIGH = 2'd1,
		SAT_LOW  = 2'd2
	} sat_t;

	typedef enum logic [IDX_W-1:0] {
		REG_SETPOINT    = 3'd0,
		REG_PROP_GAIN   = 3'd1,
		REG_DERIV_GAIN  = 3'd2,
		REG_INTEG_GAIN  = 3'd3,
		REG_INTEG_LIMIT = 3'd4,
		REG_FF_ONLY     = 3'd5,
		REG_FF_VALUE    = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		sat_t                    isat;
	} accum_res_t;

	localparam logic [SAMPLE_W-1:0]      SETPOINT_RST    = 8'd120;
	localparam logic signed [GAIN_W-1:0] PROP_GAIN_RST   = 16'sd80;
	localparam logic signed [GAIN_W-1:0] DERIV_GAIN_RST  = -16'sd120;
	localparam logic signed [GAIN_W-1:0] INTEG_GAIN_RST  = 16'sd10;
	localparam logic [LIMIT_W-1:0]       INTEG_LIMIT_RST = 16'd10000;
	localparam logic                     FF_ONLY_RST     = 1'b0;
	localparam logic signed [GAIN_W-1:0] FF_VALUE_RST    = 16'sd100;

endpackage

### hdl/pidv_accum.sv
// error sum accumulator with symmetric clamp
`timescale 1ns / 1ps

module pidv_accum (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic signed [pidv_pkg::ERR_W-1:0]     err,
	input  logic [pidv_pkg::LIMIT_W-1:0]          limit,
	output pidv_pkg::accum_res_t                  res
);
	import pidv_pkg::*;

	logic signed [SUM_W-1:0] error_sum_q;
	logic signed [SUM_W-1:0] sum_raw;
	logic signed [SUM_W-1:0] lim_pos;
	logic signed [SUM_W-1:0] lim_neg;

	always_comb begin
		sum_raw = error_sum_q + SUM_W'(err);
		lim_pos = signed'({2'b00, limit});
		lim_neg = -lim_pos;
		priority if (sum_raw > lim_pos) begin
			res.sum  = lim_pos;
			res.isat = SAT_HIGH;
		end else if (sum_raw < lim_neg) begin
			res.sum  = lim_neg;
			res.isat = SAT_LOW;
		end else begin
			res.sum  = sum_raw;
			res.isat = SAT_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q <= '0;
		end else if (en) begin
			error_sum_q <= res.sum;
		end
	end

endmodule

### hdl/pid_voltage_controller_unit.sv
// top level of the pid voltage controller: config registers and single-pass datapath
//
//  channel | signals                                   | role
//  --------+-------------------------------------------+----------------------------
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data    | register write, always ready
//  in      | in_valid in_ready sample                  | one adc word per step
//  out     | out_valid out_ready drive *_sat           | one drive word per sample
//
//  one word per cycle sustained while out_ready stays high; input register then result register
//  an accepted word moves from the input register to the result register once that register can take it
//  the error sum update closes its loop between the two registers
//  the input register loads when empty or when the result register moves
//  reset clears all valids, history and error sum, and loads register defaults
`timescale 1ns / 1ps

module pid_voltage_controller_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pidv_pkg::IDX_W-1:0]          cfg_index,
	input  logic [pidv_pkg::DATA_W-1:0]         cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [pidv_pkg::SAMPLE_W-1:0]       sample,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [7:0]                          drive,
	output pidv_pkg::sat_t                      drive_sat,
	output pidv_pkg::sat_t                      prop_sat,
	output pidv_pkg::sat_t                      deriv_sat,
	output pidv_pkg::sat_t                      integ_sat
);
	import pidv_pkg::*;

	localparam int PROD_W  = GAIN_W + ERR_W;
	localparam int PRODI_W = GAIN_W + SUM_W;
	localparam int TERM_W  = PROD_W - 7;
	localparam int ITERM_W = PRODI_W - 10;
	localparam int TOT_W   = ITERM_W + 2;

	function automatic sat_t term_sat(logic signed [TERM_W-1:0] t);
		priority if (t > TERM_W'(127)) begin
			return SAT_HIGH;
		end else if (t < -TERM_W'(127)) begin
			return SAT_LOW;
		end else begin
			return SAT_NONE;
		end
	endfunction

	// config registers
	logic [SAMPLE_W-1:0]      setpoint_q;
	logic signed [GAIN_W-1:0] prop_gain_q;
	logic signed [GAIN_W-1:0] deriv_gain_q;
	logic signed [GAIN_W-1:0] integ_gain_q;
	logic [LIMIT_W-1:0]       integ_limit_q;
	logic                     ff_only_q;
	logic signed [GAIN_W-1:0] ff_value_q;

	// history
	logic [SAMPLE_W-1:0] last_sample_q;
	logic                have_last_q;

	// datapath
	logic valid_s1, out_valid_q;
	logic rdy_out, adv1;

	logic [SAMPLE_W-1:0]        sample_s1;
	logic signed [ERR_W-1:0]    err_c, delta_c;
	accum_res_t                 acc_res;
	logic signed [PROD_W-1:0]   prod_p_c, prod_d_c;
	logic signed [PRODI_W-1:0]  prod_i_c;
	logic [PROD_W-1:0]          p_bias, d_bias;
	logic [PRODI_W-1:0]         i_bias;
	logic signed [TERM_W-1:0]   pterm_c, dterm_c;
	logic signed [ITERM_W-1:0]  iterm_c;
	logic signed [TOT_W-1:0]    total_c, v_c;
	logic [7:0]                 drive_c;
	sat_t                       dsat_c;
	logic [7:0]                 drive_q;
	sat_t                       drive_sat_q, prop_sat_q, deriv_sat_q, integ_sat_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q    <= SETPOINT_RST;
			prop_gain_q   <= PROP_GAIN_RST;
			deriv_gain_q  <= DERIV_GAIN_RST;
			integ_gain_q  <= INTEG_GAIN_RST;
			integ_limit_q <= INTEG_LIMIT_RST;
			ff_only_q     <= FF_ONLY_RST;
			ff_value_q    <= FF_VALUE_RST;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SETPOINT:    setpoint_q    <= cfg_data[SAMPLE_W-1:0];
				REG_PROP_GAIN:   prop_gain_q   <= signed'(cfg_data);
				REG_DERIV_GAIN:  deriv_gain_q  <= signed'(cfg_data);
				REG_INTEG_GAIN:  integ_gain_q  <= signed'(cfg_data);
				REG_INTEG_LIMIT: integ_limit_q <= cfg_data;
				REG_FF_ONLY:     ff_only_q     <= cfg_data[0];
				REG_FF_VALUE:    ff_value_q    <= signed'(cfg_data);
				default: ;
			endcase
		end
	end

	// ready chain
	always_comb begin
		rdy_out  = !out_valid_q || out_ready;
		in_ready = !valid_s1 || rdy_out;
		adv1     = valid_s1 && rdy_out;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			out_valid_q   <= 1'b0;
			last_sample_q <= '0;
			have_last_q   <= 1'b0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (rdy_out) out_valid_q <= valid_s1;
			if (adv1) begin
				last_sample_q <= sample_s1;
				have_last_q   <= 1'b1;
			end
		end
	end

	// error, delta, error sum
	always_comb begin
		err_c   = signed'({1'b0, setpoint_q}) - signed'({1'b0, sample_s1});
		delta_c = have_last_q ? signed'({1'b0, sample_s1}) - signed'({1'b0, last_sample_q})
		                      : '0;
	end

	pidv_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv1),
		.err    (err_c),
		.limit  (integ_limit_q),
		.res    (acc_res)
	);

	// products and rounding toward zero
	always_comb begin
		prod_p_c = prop_gain_q * err_c;
		prod_d_c = deriv_gain_q * delta_c;
		prod_i_c = integ_gain_q * acc_res.sum;
		p_bias   = prod_p_c + {{(PROD_W-7){1'b0}}, {7{prod_p_c[PROD_W-1]}}};
		d_bias   = prod_d_c + {{(PROD_W-7){1'b0}}, {7{prod_d_c[PROD_W-1]}}};
		i_bias   = prod_i_c + {{(PRODI_W-10){1'b0}}, {10{prod_i_c[PRODI_W-1]}}};
		pterm_c  = p_bias[PROD_W-1:7];
		dterm_c  = d_bias[PROD_W-1:7];
		iterm_c  = i_bias[PRODI_W-1:10];
	end

	// sum, select, clamp
	always_comb begin
		total_c = TOT_W'(pterm_c) + TOT_W'(dterm_c) + TOT_W'(iterm_c);
		v_c     = ff_only_q ? TOT_W'(ff_value_q) : total_c;
		priority if (v_c > TOT_W'(255)) begin
			drive_c = 8'hff;
			dsat_c  = SAT_HIGH;
		end else if (v_c < 0) begin
			drive_c = 8'h00;
			dsat_c  = SAT_LOW;
		end else begin
			drive_c = v_c[7:0];
			dsat_c  = SAT_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_s1 <= sample;
		end
		if (adv1) begin
			drive_q     <= drive_c;
			drive_sat_q <= dsat_c;
			prop_sat_q  <= term_sat(pterm_c);
			deriv_sat_q <= term_sat(dterm_c);
			integ_sat_q <= acc_res.isat;
		end
	end

	assign out_valid = out_valid_q;
	assign drive     = drive_q;
	assign drive_sat = drive_sat_q;
	assign prop_sat  = prop_sat_q;
	assign deriv_sat = deriv_sat_q;
	assign integ_sat = integ_sat_q;

endmodule

### hdl/pidv_check.sv
// port-level checks for the pid voltage controller and their binding
`timescale 1ns / 1ps

module pidv_check (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [7:0]          drive,
	input pidv_pkg::sat_t      drive_sat
);
	import pidv_pkg::*;

	// high clamp shows full scale
	a_sat_high: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && drive_sat == SAT_HIGH) |-> drive == 8'hff)
		else $error("drive high clamp without full scale");

	// low clamp shows zero
	a_sat_low: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && drive_sat == SAT_LOW) |-> drive == 8'h00)
		else $error("drive low clamp without zero");

	// a free output side never blocks the input
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output side ready");

	// fixed latency when the output side keeps taking words
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) ##1 out_ready |=> out_valid)
		else $error("result word missing after pipeline latency");

	// stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(drive) && $stable(drive_sat)))
		else $error("stalled result word changed");

endmodule

bind pid_voltage_controller_unit pidv_check u_pidv_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.drive     (drive),
	.drive_sat (drive_sat)
);
